// ----- rtl/core/ssoc_pkg.sv -----
// Shared constants, codes and types of the sorted set overlap counter.
package ssoc_pkg;

  localparam int LIST_CAPACITY = 1024;
  localparam int ID_WIDTH      = 32;
  localparam int ADDR_W        = $clog2(LIST_CAPACITY);
  localparam int CNT_W         = $clog2(LIST_CAPACITY + 1);

  localparam int OP_W          = 2;
  localparam int ELEM_W        = 32;
  localparam int UNION_W       = 12;
  localparam int COUNT_OUT_W   = 11;

  localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic adv_a;
    logic adv_b;
    logic match;
  } step_t;

endpackage

// ----- rtl/core/ssoc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ssoc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ssoc_cmp.sv -----
// Shared head comparator that decides one step of the merge walk.
module ssoc_cmp
  import ssoc_pkg::*;
(
  input  logic [ID_WIDTH-1:0] head_a,
  input  logic [ID_WIDTH-1:0] head_b,
  output step_t               step
);

  logic lt;
  logic gt;

  assign lt = head_a < head_b;
  assign gt = head_b < head_a;

  // Equal heads consume both sides and count once as shared.
  always_comb begin
    step.adv_a = !gt;
    step.adv_b = !lt;
    step.match = !lt && !gt;
  end

endmodule

// ----- rtl/core/sorted_set_overlap_counter.sv -----
// Top level of the sorted set overlap counter: list storage, sequencer and counts.
//
// Usage: an item is transferred when start is high and busy is low. Op append A
// or append B writes element (low ID_WIDTH bits) to the end of that list;
// busy stays low, so appends can be issued every cycle. An append to a
// full list is dropped and sets the overflow flag. Op 3 is taken and ignored.
// Op compute merge-walks both lists with one shared comparator, fed by the
// registered read ports of the two list RAMs. After the transfer a prime state
// starts the reads (skipped when a list is empty), then walk steps make one
// comparison each (at most count_a + count_b - 1, none if a list is empty),
// then a finish state forms the counts. done is registered from the finish
// state and is high for one cycle, together with union_size, intersection_size,
// left_only, right_only and overflow. Both lists and the flag are then empty.
// Results are not held: the receiver takes them in the done cycle and cannot
// stall. busy is high from the cycle after a compute transfer until done.
// A synchronous reset empties both lists and clears the overflow flag; the RAM
// contents are not cleared and are never read before being written.
module sorted_set_overlap_counter
  import ssoc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        op,
  input  logic [ELEM_W-1:0]      element,
  output logic                   done,
  output logic [UNION_W-1:0]     union_size,
  output logic [COUNT_OUT_W-1:0] intersection_size,
  output logic [COUNT_OUT_W-1:0] left_only,
  output logic [COUNT_OUT_W-1:0] right_only,
  output logic                   overflow
);

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0]    count_a;
  logic [CNT_W-1:0]    count_b;
  logic [CNT_W-1:0]    ia;
  logic [CNT_W-1:0]    ib;
  logic [CNT_W-1:0]    ia_next;
  logic [CNT_W-1:0]    ib_next;
  logic [CNT_W-1:0]    both;
  logic [CNT_W-1:0]    both_next;
  logic                dropped;

  logic                accept;
  logic                we_a;
  logic                we_b;
  logic [ADDR_W-1:0]   raddr_a;
  logic [ADDR_W-1:0]   raddr_b;
  logic [ID_WIDTH-1:0] head_a;
  logic [ID_WIDTH-1:0] head_b;
  logic [ID_WIDTH-1:0] wdata;
  step_t               step;

  assign accept = start && !busy;
  assign wdata  = ID_WIDTH'(element);

  ssoc_ram #(
    .DEPTH (LIST_CAPACITY),
    .WIDTH (ID_WIDTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (head_a)
  );

  ssoc_ram #(
    .DEPTH (LIST_CAPACITY),
    .WIDTH (ID_WIDTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[ADDR_W-1:0]),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (head_b)
  );

  ssoc_cmp u_cmp (
    .head_a (head_a),
    .head_b (head_b),
    .step   (step)
  );

  assign ia_next   = ia + CNT_W'(step.adv_a);
  assign ib_next   = ib + CNT_W'(step.adv_b);
  assign both_next = both + CNT_W'(step.match);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && op == OP_COMPUTE) begin
          if (count_a == '0 || count_b == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (ia_next == count_a || ib_next == count_b) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // During the walk the reads run one step ahead, so a head pair is compared
  // every cycle.
  always_comb begin
    busy    = (state != ST_IDLE);
    we_a    = accept && op == OP_APPEND_A && count_a < CNT_W'(LIST_CAPACITY);
    we_b    = accept && op == OP_APPEND_B && count_b < CNT_W'(LIST_CAPACITY);
    raddr_a = ia[ADDR_W-1:0];
    raddr_b = ib[ADDR_W-1:0];
    if (state == ST_WALK) begin
      raddr_a = ia_next[ADDR_W-1:0];
      raddr_b = ib_next[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count_a <= '0;
      count_b <= '0;
      dropped <= 1'b0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINISH);
      if (state == ST_FINISH) begin
        count_a <= '0;
        count_b <= '0;
        dropped <= 1'b0;
      end else begin
        if (we_a) begin
          count_a <= count_a + CNT_W'(1);
        end
        if (we_b) begin
          count_b <= count_b + CNT_W'(1);
        end
        if (accept && ((op == OP_APPEND_A && !we_a) || (op == OP_APPEND_B && !we_b))) begin
          dropped <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_COMPUTE) begin
      ia   <= '0;
      ib   <= '0;
      both <= '0;
    end else if (state == ST_WALK) begin
      ia   <= ia_next;
      ib   <= ib_next;
      both <= both_next;
    end
  end

  // Every element of a list is either shared or only on its own side.
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      intersection_size <= COUNT_OUT_W'(both);
      left_only         <= COUNT_OUT_W'(count_a - both);
      right_only        <= COUNT_OUT_W'(count_b - both);
      union_size        <= UNION_W'({1'b0, count_a} + {1'b0, count_b} - {1'b0, both});
      overflow          <= dropped;
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("done without a finish cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && count_a == '0 && count_b == '0)
    else $error("lists not emptied when the result is shown");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> ia < count_a && ib < count_b)
    else $error("merge walk index past the end of a list");

  a_shared_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> both <= ia && both <= ib)
    else $error("shared count exceeds consumed elements");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !we_a && !we_b)
    else $error("list written during a compute");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the sorted set overlap counter with its own merge-walk predictor.
module tb;
  import ssoc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [UNION_W-1:0]     union_n;
    logic [COUNT_OUT_W-1:0] shared_n;
    logic [COUNT_OUT_W-1:0] a_only_n;
    logic [COUNT_OUT_W-1:0] b_only_n;
    logic                   lost;
  } overlap_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [OP_W-1:0]        op = OP_APPEND_A;
  logic [ELEM_W-1:0]      element = '0;
  logic                   busy;
  logic                   done;
  logic [UNION_W-1:0]     union_size;
  logic [COUNT_OUT_W-1:0] intersection_size;
  logic [COUNT_OUT_W-1:0] left_only;
  logic [COUNT_OUT_W-1:0] right_only;
  logic                   overflow;

  // Predictor state: the two lists as the block should hold them.
  logic [ID_WIDTH-1:0] held_a [LIST_CAPACITY];
  logic [ID_WIDTH-1:0] held_b [LIST_CAPACITY];
  int unsigned         held_cnt_a = 0;
  int unsigned         held_cnt_b = 0;
  bit                  held_lost = 1'b0;

  overlap_t pending_counts[$];
  int       mismatch_count = 0;
  int       random_items = 0;
  bit       no_gaps = 1'b0;

  sorted_set_overlap_counter u_dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .op                (op),
    .element           (element),
    .done              (done),
    .union_size        (union_size),
    .intersection_size (intersection_size),
    .left_only         (left_only),
    .right_only        (right_only),
    .overflow          (overflow)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("Some tests failed");
    $finish;
  end

  function automatic overlap_t merge_counts();
    overlap_t    res;
    int unsigned ia, ib, both, left, right;
    ia = 0;
    ib = 0;
    both = 0;
    left = 0;
    right = 0;
    while (ia < held_cnt_a && ib < held_cnt_b) begin
      if (held_a[ia] < held_b[ib]) begin
        left++;
        ia++;
      end else if (held_b[ib] < held_a[ia]) begin
        right++;
        ib++;
      end else begin
        both++;
        ia++;
        ib++;
      end
    end
    left += held_cnt_a - ia;
    right += held_cnt_b - ib;
    res.union_n  = UNION_W'(both + left + right);
    res.shared_n = COUNT_OUT_W'(both);
    res.a_only_n = COUNT_OUT_W'(left);
    res.b_only_n = COUNT_OUT_W'(right);
    res.lost     = held_lost;
    return res;
  endfunction

  function automatic void apply_item(input logic [OP_W-1:0] code, input logic [ELEM_W-1:0] value);
    case (code)
      OP_APPEND_A: begin
        if (held_cnt_a < LIST_CAPACITY) begin
          held_a[held_cnt_a] = value[ID_WIDTH-1:0];
          held_cnt_a++;
        end else begin
          held_lost = 1'b1;
        end
      end
      OP_APPEND_B: begin
        if (held_cnt_b < LIST_CAPACITY) begin
          held_b[held_cnt_b] = value[ID_WIDTH-1:0];
          held_cnt_b++;
        end else begin
          held_lost = 1'b1;
        end
      end
      OP_COMPUTE: begin
        pending_counts.push_back(merge_counts());
        held_cnt_a = 0;
        held_cnt_b = 0;
        held_lost = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One transfer: optional idle gap, then hold start until busy is seen low at an edge.
  task automatic send_item(input logic [OP_W-1:0] code, input logic [ELEM_W-1:0] value);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      op <= 2'($urandom);
      element <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= code;
    element <= value;
    do @(posedge clk); while (busy);
    apply_item(code, value);
  endtask

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("Mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk) begin
    overlap_t want;
    if (!rst && done) begin
      if (pending_counts.size() == 0) begin
        report_mismatch("result with no compute pending", 0, union_size);
      end else begin
        want = pending_counts.pop_front();
        if (union_size !== want.union_n)
          report_mismatch("union_size", want.union_n, union_size);
        if (intersection_size !== want.shared_n)
          report_mismatch("intersection_size", want.shared_n, intersection_size);
        if (left_only !== want.a_only_n)
          report_mismatch("left_only", want.a_only_n, left_only);
        if (right_only !== want.b_only_n)
          report_mismatch("right_only", want.b_only_n, right_only);
        if (overflow !== want.lost)
          report_mismatch("overflow", want.lost, overflow);
      end
    end
  end

  task automatic test_empty_lists();
    send_item(OP_COMPUTE, 32'h0);
    send_item(OP_COMPUTE, 32'hFFFF_FFFF);
  endtask

  task automatic test_field_extremes();
    send_item(OP_APPEND_A, 32'h0000_0000);
    send_item(OP_APPEND_B, 32'h0000_0001);
    send_item(OP_APPEND_A, 32'h0000_0001);
    send_item(OP_APPEND_B, 32'h7FFF_FFFF);
    send_item(OP_APPEND_A, 32'h8000_0000);
    send_item(OP_APPEND_A, 32'hFFFF_FFFF);
    send_item(OP_APPEND_B, 32'hFFFF_FFFF);
    send_item(OP_COMPUTE, 32'h5555_AAAA);
  endtask

  task automatic test_one_sided();
    send_item(OP_APPEND_A, 32'd10);
    send_item(OP_APPEND_A, 32'd20);
    send_item(OP_APPEND_A, 32'd30);
    send_item(OP_COMPUTE, 32'h0);
    send_item(OP_APPEND_B, 32'd5);
    send_item(OP_COMPUTE, 32'h0);
  endtask

  task automatic test_unsorted_input();
    send_item(OP_APPEND_A, 32'd9);
    send_item(OP_APPEND_A, 32'd4);
    send_item(OP_APPEND_B, 32'd4);
    send_item(OP_APPEND_A, 32'd4);
    send_item(OP_APPEND_B, 32'd9);
    send_item(OP_APPEND_A, 32'd12);
    send_item(OP_APPEND_B, 32'd1);
    send_item(OP_COMPUTE, 32'h0);
  endtask

  task automatic test_ignored_op();
    send_item(OP_APPEND_A, 32'd3);
    send_item(OP_UNUSED, 32'd2);
    send_item(OP_APPEND_B, 32'd3);
    send_item(OP_UNUSED, $urandom);
    send_item(OP_COMPUTE, 32'h0);
  endtask

  // Both lists filled to capacity: once identical with drops, once interleaved and disjoint.
  task automatic test_full_lists();
    no_gaps = 1'b1;
    for (int i = 0; i < LIST_CAPACITY + 2; i++) begin
      send_item(OP_APPEND_A, 32'(i * 3 + 7));
      send_item(OP_APPEND_B, 32'(i * 3 + 7));
    end
    send_item(OP_COMPUTE, 32'h0);
    for (int i = 0; i < LIST_CAPACITY; i++) begin
      send_item(OP_APPEND_B, 32'(2 * i + 1));
      send_item(OP_APPEND_A, 32'(2 * i));
    end
    send_item(OP_COMPUTE, 32'h0);
    no_gaps = 1'b0;
  endtask

  // One random set pair: ascending ids split between A, B or both, loaded interleaved.
  task automatic send_random_sets(input int max_len);
    logic [ELEM_W-1:0] seq_a[$];
    logic [ELEM_W-1:0] seq_b[$];
    logic [ELEM_W:0]   val;
    int                len, pick, ia, ib, spread;
    len = $urandom_range(0, max_len);
    spread = $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0: val = {1'b0, $urandom};
      1: val = 33'h0_FFFF_FFFF - 33'($urandom_range(0, 40));
      default: val = 33'($urandom_range(0, 64));
    endcase
    for (int i = 0; i < len; i++) begin
      if (val > 33'h0_FFFF_FFFF) break;
      pick = $urandom_range(0, 2);
      if (pick != 1) seq_a.push_back(val[ELEM_W-1:0]);
      if (pick != 0) seq_b.push_back(val[ELEM_W-1:0]);
      val += (spread == 0) ? 33'($urandom_range(1, 32'h0FFF_FFFF)) : 33'($urandom_range(1, 4));
    end
    // A few broken sets: a duplicate or an out-of-order id.
    if ($urandom_range(0, 7) == 0 && seq_a.size() > 0)
      seq_a.insert($urandom_range(0, seq_a.size()), seq_a[$urandom_range(0, seq_a.size() - 1)]);
    if ($urandom_range(0, 9) == 0)
      seq_b.insert($urandom_range(0, seq_b.size()), $urandom);
    no_gaps = ($urandom_range(0, 3) == 0);
    ia = 0;
    ib = 0;
    while (ia < seq_a.size() || ib < seq_b.size()) begin
      if ($urandom_range(0, 24) == 0)
        send_item(OP_UNUSED, $urandom);
      if (ib >= seq_b.size() || (ia < seq_a.size() && $urandom_range(0, 1) == 0)) begin
        send_item(OP_APPEND_A, seq_a[ia]);
        ia++;
      end else begin
        send_item(OP_APPEND_B, seq_b[ib]);
        ib++;
      end
      random_items++;
    end
    send_item(OP_COMPUTE, $urandom);
    random_items++;
    no_gaps = 1'b0;
  endtask

  task automatic test_random_sets();
    while (random_items < 650)
      send_random_sets(($urandom_range(0, 9) == 0) ? 80 : 12);
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_lists();
    test_field_extremes();
    test_one_sided();
    test_unsorted_input();
    test_ignored_op();
    test_full_lists();
    test_random_sets();
    start <= 1'b0;
    waited = 0;
    while (pending_counts.size() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_counts.size() > 0)
      report_mismatch("results still outstanding", 0, pending_counts.size());
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
